>>> rtl/utf8_latin1_case_converter_defines.svh
// Assertion macros shared by the case converter RTL.
`ifndef UTF8_LATIN1_CASE_CONVERTER_DEFINES_SVH
`define UTF8_LATIN1_CASE_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define UCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ucc: assertion failed");
`define UCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `UCC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define UCC_ASSERT(lbl, clk, rst_n, prop)
`define UCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ucc_pkg.sv
// Types, constants and case-mapping functions of the UTF-8 case converter.
`timescale 1ns / 1ps
`default_nettype none
package ucc_pkg;

  localparam int QUEUE_DEPTH = 4;

  // One finished sequence: up to four output bytes, index of the last one.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            str_end;
  } ucc_job_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } ucc_map_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    return len;
  endfunction

  // Only ASCII and Latin-1 letters have partners; the multiply and divide
  // signs are skipped.
  function automatic ucc_map_t case_map(input logic [20:0] cp, input logic up);
    ucc_map_t m;
    m.hit   = 1'b0;
    m.value = cp[7:0];
    if (up) begin
      if ((cp >= 21'h61 && cp <= 21'h7A) ||
          (cp >= 21'hE0 && cp <= 21'hFE && cp != 21'hF7)) begin
        m.hit   = 1'b1;
        m.value = cp[7:0] - 8'd32;
      end
    end else begin
      if ((cp >= 21'h41 && cp <= 21'h5A) ||
          (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7)) begin
        m.hit   = 1'b1;
        m.value = cp[7:0] + 8'd32;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ucc_front.sv
// Front end: gathers UTF-8 sequences, case-maps them and builds output jobs.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_latin1_case_converter_defines.svh"
module ucc_front
  import ucc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       to_upper,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       q_full,
  output logic            push,
  output ucc_job_t        push_job
);

  logic [2:0]      exp_r, exp_nxt;
  logic [2:0]      seen_r, seen_nxt;
  logic [20:0]     pp_r, pp_nxt;
  logic            zero_r, zero_nxt;
  logic [3:0][7:0] held_r, held_nxt;
  logic [2:0]      len;
  logic            accept;
  logic            complete;
  logic [2:0]      seen_m1;
  ucc_map_t        map;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    held_nxt = held_r;
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    pp_nxt   = pp_r;
    zero_nxt = zero_r;
    len      = lead_len(in_tdata);
    if (exp_r == 3'd0) begin
      held_nxt[0] = in_tdata;
      seen_nxt    = 3'd1;
      zero_nxt    = 1'b0;
      exp_nxt     = len;
      pp_nxt      = (len == 3'd1) ? {13'd0, in_tdata} : {13'd0, in_tdata & (8'h7F >> len)};
    end else begin
      held_nxt[seen_r[1:0]] = in_tdata;
      // A zero byte freezes the code point but still counts toward the length.
      if (!zero_r) begin
        if (in_tdata == 8'h00) zero_nxt = 1'b1;
        else pp_nxt = {pp_r[14:0], in_tdata[5:0]};
      end
      seen_nxt = seen_r + 3'd1;
    end
    complete = (seen_nxt >= exp_nxt) || in_tlast;
  end

  assign map     = case_map(pp_nxt, to_upper);
  assign seen_m1 = seen_nxt - 3'd1;

  always_comb begin
    push_job.data     = held_nxt;
    push_job.last_idx = seen_m1[1:0];
    push_job.str_end  = in_tlast;
    if (map.hit) begin
      if (map.value < 8'h80) begin
        push_job.data[0]  = map.value;
        push_job.last_idx = 2'd0;
      end else begin
        push_job.data[0]  = {6'b110000, map.value[7:6]};
        push_job.data[1]  = {2'b10, map.value[5:0]};
        push_job.last_idx = 2'd1;
      end
    end
  end

  assign push = accept && complete;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 3'd0;
      seen_r <= 3'd0;
      pp_r   <= 21'd0;
      zero_r <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        exp_r  <= 3'd0;
        seen_r <= 3'd0;
        pp_r   <= 21'd0;
        zero_r <= 1'b0;
      end else begin
        exp_r  <= exp_nxt;
        seen_r <= seen_nxt;
        pp_r   <= pp_nxt;
        zero_r <= zero_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

  // An open sequence has seen at least its lead and fewer bytes than it needs.
  `UCC_ASSERT_IMP(a_open_seq, clk, rst_n, exp_r != 3'd0, seen_r != 3'd0 && seen_r < exp_r)
  `UCC_ASSERT(a_len_range, clk, rst_n, exp_r <= 3'd4)

endmodule
`default_nettype wire

>>> rtl/ucc_queue.sv
// Short job queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_latin1_case_converter_defines.svh"
module ucc_queue
  import ucc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire ucc_job_t push_job,
  input  wire logic     pop,
  output ucc_job_t      head,
  output logic          q_valid,
  output logic          q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ucc_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  `UCC_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH))
  `UCC_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_full)
  `UCC_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, q_valid)

endmodule
`default_nettype wire

>>> rtl/ucc_back.sv
// Back end: emits the bytes of each queued job through an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_latin1_case_converter_defines.svh"
module ucc_back
  import ucc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ucc_job_t head,
  input  wire logic     q_valid,
  output logic          pop,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic [0:0]    out_tuser
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       end_r;
  logic       run_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       at_last;

  assign load    = q_valid && (!valid_r || out_tready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.data[idx_r];
      run_r  <= at_last;
      end_r  <= at_last && head.str_end;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = data_r;
  assign out_tlast    = end_r;
  assign out_tuser[0] = run_r;

  // The byte index never runs past the end of the job at the head.
  `UCC_ASSERT_IMP(a_idx_in_job, clk, rst_n, q_valid, idx_r <= head.last_idx)

endmodule
`default_nettype wire

>>> rtl/utf8_latin1_case_converter.sv
// UTF-8 case converter for ASCII and Latin-1 letters: top level.
// Takes one byte of a UTF-8 string per beat and emits the string with
// ASCII and Latin-1 letters moved to upper case (cfg_data = 1, the reset
// value) or lower case (cfg_data = 0). Sequences are gathered leniently,
// and a sequence cut off by tlast is finished from the bytes received.
// The input accepts one byte every cycle unless the queue is full, and the
// output gives one byte every cycle while a job is queued and out_tready is
// high. A mapped character may grow from one byte to two, and the job queue
// of QUEUE_DEPTH finished sequences between the gathering front end and the
// byte emitter absorbs that; in_tready falls only while the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module utf8_latin1_case_converter
  import ucc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,    // to_upper
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] in_byte
  input  wire logic       in_tlast,    // in_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] out_byte
  output logic            out_tlast,   // string_end
  output logic [0:0]      out_tuser    // [0] run_last
);

  logic     to_upper_r;
  logic     push;
  logic     pop;
  logic     q_valid;
  logic     q_full;
  ucc_job_t push_job;
  ucc_job_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_upper_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      to_upper_r <= cfg_data;
    end
  end

  ucc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .to_upper  (to_upper_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  ucc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  ucc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_valid    (q_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
